/* rtl/dnsw_pkg.sv */
// Shared constants for the DNS name to wire format encoder.
package dnsw_pkg;

  localparam int CHAR_W          = 8;
  localparam int COUNT_W         = 12;
  localparam int LABEL_DEPTH_DEF = 63;

  localparam logic [CHAR_W-1:0]  DOT_CHAR  = 8'h2E;
  localparam logic [CHAR_W-1:0]  NUL_CHAR  = 8'h00;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

/* rtl/dnsw_char_if.sv */
// Input channel: one name character per beat.
interface dnsw_char_if;
  import dnsw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] name_char;

  modport source (output valid, output name_char, input ready);
  modport sink   (input valid, input name_char, output ready);
endinterface

/* rtl/dnsw_wire_if.sv */
// Output channel: one wire format byte per beat with its status.
interface dnsw_wire_if;
  import dnsw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  wire_byte;
  logic               name_done;
  logic [COUNT_W-1:0] wire_count;
  logic               label_overlong;

  modport source (output valid, output wire_byte, output name_done, output wire_count,
                  output label_overlong, input ready);
  modport sink   (input valid, input wire_byte, input name_done, input wire_count,
                  input label_overlong, output ready);
endinterface

/* rtl/dns_name_to_wire_encoder_core.sv */
// Top level: dotted DNS name in, wire format bytes out, label held in a RAM.
//
//   channel   dir  payload                                          handshake
//   name_ch   in   name_char[7:0]                                   valid/ready
//   wire_ch   out  wire_byte[7:0] name_done wire_count[11:0]        valid/ready
//                  label_overlong
//
// A label character is written to the label RAM while the label has room.
// A dot or NUL then flushes the label: the length byte and then each buffered
// byte, after a held leading zero byte if there is one; name_ch is not ready
// meanwhile. The RAM read address runs one index ahead of the byte index.
// rst is synchronous; the label RAM is not cleared, only entries below the
// count are read. A stalled wire_ch holds the sequencer on its current byte.
module dns_name_to_wire_encoder_core #(
  parameter int MAX_LABEL = dnsw_pkg::LABEL_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  dnsw_char_if.sink   name_ch,
  dnsw_wire_if.source wire_ch
);
  import dnsw_pkg::*;

  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int CW = $clog2(MAX_LABEL + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ZERO = 2'd1;
  localparam logic [1:0] S_LEN  = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  logic [1:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      idx, idx_next;
  logic               at_start, at_start_next;
  logic               root_pending, root_next;
  logic               overlong, overlong_next;
  logic               flush_nul, flush_nul_next;
  logic               zero_done, zero_done_next;
  logic               zero_flush, zero_flush_next;
  logic [COUNT_W-1:0] bytes_out, bytes_out_next;

  logic [CHAR_W-1:0]  label_mem [MAX_LABEL];
  logic [CHAR_W-1:0]  rd_data;

  logic               out_valid;
  logic [CHAR_W-1:0]  out_byte;
  logic               out_done;
  logic [COUNT_W-1:0] out_count;
  logic               out_ovl;

  logic               accept, slot_free, take_char, mem_we, finish, end_name, last;
  logic               emit, emit_done, emit_ovl;
  logic [CHAR_W-1:0]  emit_byte;
  logic [COUNT_W-1:0] cnt_inc;

  assign name_ch.ready = (state == S_IDLE);
  assign accept        = name_ch.valid && name_ch.ready;
  assign slot_free     = !out_valid || wire_ch.ready;
  assign last          = ((CW'(idx) + CW'(1)) == count);
  assign cnt_inc       = (bytes_out == COUNT_MAX) ? bytes_out : bytes_out + COUNT_W'(1);

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    at_start_next   = at_start;
    root_next       = root_pending;
    overlong_next   = overlong;
    flush_nul_next  = flush_nul;
    zero_done_next  = zero_done;
    zero_flush_next = zero_flush;
    bytes_out_next  = bytes_out;
    take_char       = 1'b0;
    mem_we          = 1'b0;
    finish          = 1'b0;
    end_name        = 1'b0;
    emit            = 1'b0;
    emit_byte       = '0;
    emit_done       = 1'b0;
    emit_ovl        = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          at_start_next = 1'b0;
          if (at_start && name_ch.name_char == DOT_CHAR) begin
            root_next = 1'b1;
          end else if (root_pending) begin
            // held leading dot: zero byte first, then this character
            root_next       = 1'b0;
            state_next      = S_ZERO;
            zero_done_next  = (name_ch.name_char == NUL_CHAR);
            zero_flush_next = (name_ch.name_char == DOT_CHAR);
            flush_nul_next  = 1'b0;
            take_char       = (name_ch.name_char != NUL_CHAR) &&
                              (name_ch.name_char != DOT_CHAR);
          end else if (name_ch.name_char == DOT_CHAR) begin
            state_next     = S_LEN;
            flush_nul_next = 1'b0;
          end else if (name_ch.name_char == NUL_CHAR) begin
            state_next     = S_LEN;
            flush_nul_next = 1'b1;
          end else begin
            take_char = 1'b1;
          end
        end
      end
      S_ZERO: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_done = zero_done;
          if (zero_done) begin
            end_name   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = zero_flush ? S_LEN : S_IDLE;
          end
        end
      end
      S_LEN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = CHAR_W'(count);
          emit_done = flush_nul && (count == '0);
          emit_ovl  = overlong;
          if (count == '0) begin
            finish = 1'b1;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = rd_data;
          emit_done = flush_nul && last;
          emit_ovl  = overlong;
          if (last) begin
            finish = 1'b1;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (take_char) begin
      if (count < CW'(MAX_LABEL)) begin
        mem_we     = 1'b1;
        count_next = count + CW'(1);
      end else begin
        overlong_next = 1'b1;
      end
    end

    if (finish) begin
      count_next    = '0;
      idx_next      = '0;
      overlong_next = 1'b0;
      state_next    = S_IDLE;
      end_name      = flush_nul;
    end

    if (emit) begin
      bytes_out_next = cnt_inc;
    end

    if (end_name) begin
      count_next     = '0;
      overlong_next  = 1'b0;
      at_start_next  = 1'b1;
      root_next      = 1'b0;
      bytes_out_next = '0;
    end
  end

  // label RAM: write while buffering, read one index ahead while flushing
  always_ff @(posedge clk) begin
    if (mem_we) begin
      label_mem[count[AW-1:0]] <= name_ch.name_char;
    end
    rd_data <= label_mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      idx          <= '0;
      at_start     <= 1'b1;
      root_pending <= 1'b0;
      overlong     <= 1'b0;
      flush_nul    <= 1'b0;
      zero_done    <= 1'b0;
      zero_flush   <= 1'b0;
      bytes_out    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      idx          <= idx_next;
      at_start     <= at_start_next;
      root_pending <= root_next;
      overlong     <= overlong_next;
      flush_nul    <= flush_nul_next;
      zero_done    <= zero_done_next;
      zero_flush   <= zero_flush_next;
      bytes_out    <= bytes_out_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (wire_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= emit_byte;
      out_done  <= emit_done;
      out_count <= cnt_inc;
      out_ovl   <= emit_ovl;
    end
  end

  assign wire_ch.valid          = out_valid;
  assign wire_ch.wire_byte      = out_byte;
  assign wire_ch.name_done      = out_done;
  assign wire_ch.wire_count     = out_count;
  assign wire_ch.label_overlong = out_ovl;

endmodule

/* rtl/dnsw_checker.sv */
// Port-level checks for the DNS name encoder, bound to the top level.
module dnsw_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [dnsw_pkg::CHAR_W-1:0]     name_char,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dnsw_pkg::CHAR_W-1:0]     wire_byte,
  input logic                            name_done,
  input logic [dnsw_pkg::COUNT_W-1:0]    wire_count,
  input logic                            label_overlong
);
  import dnsw_pkg::*;

  // a stalled beat keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wire_byte) && $stable(name_done) &&
      $stable(wire_count) && $stable(label_overlong))
    else $error("output beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // every emitted byte counts itself
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wire_count != '0)
    else $error("wire count zero on an output beat");

  // end of name always produces output, so input must stall
  a_nul_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && name_char == NUL_CHAR |=> !in_ready)
    else $error("input ready right after end of name");

endmodule

bind dns_name_to_wire_encoder_core dnsw_checker u_dnsw_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (name_ch.valid),
  .in_ready       (name_ch.ready),
  .name_char      (name_ch.name_char),
  .out_valid      (wire_ch.valid),
  .out_ready      (wire_ch.ready),
  .wire_byte      (wire_ch.wire_byte),
  .name_done      (wire_ch.name_done),
  .wire_count     (wire_ch.wire_count),
  .label_overlong (wire_ch.label_overlong)
);

/* tb/tb_dns_name_to_wire_encoder_core.sv */
// Self-checking testbench for the DNS name to wire format encoder core.
`timescale 1ns / 100ps

module tb_dns_name_to_wire_encoder_core;
  import dnsw_pkg::*;

  localparam int LBL_DEPTH = LABEL_DEPTH_DEF;
  localparam int N_DIR     = 24;
  localparam int N_RAND    = 144;

  typedef struct packed {
    logic [CHAR_W-1:0]  wbyte;
    logic               done;
    logic [COUNT_W-1:0] cnt;
    logic               ovl;
  } wire_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              has;
    wire_beat_t        want;
  } char_row_t;

  // Directed rows; a typed result is the last beat that the character causes.
  localparam char_row_t DIR_TAB [N_DIR] = '{
    '{NUL_CHAR, 1'b1, '{8'h00, 1'b1, 12'd1, 1'b0}},  // empty name right after reset
    '{DOT_CHAR, 1'b0, '0},                           // root name
    '{NUL_CHAR, 1'b1, '{8'h00, 1'b1, 12'd1, 1'b0}},
    '{DOT_CHAR, 1'b0, '0},                           // ".." : three zero bytes
    '{DOT_CHAR, 1'b1, '{8'h00, 1'b0, 12'd2, 1'b0}},
    '{NUL_CHAR, 1'b1, '{8'h00, 1'b1, 12'd3, 1'b0}},
    '{8'h61,    1'b0, '0},                           // byte extremes as label data
    '{8'hFF,    1'b0, '0},
    '{8'h01,    1'b0, '0},
    '{8'h80,    1'b0, '0},
    '{DOT_CHAR, 1'b0, '0},
    '{8'h7F,    1'b0, '0},
    '{NUL_CHAR, 1'b0, '0},                           // last label, no trailing dot
    '{DOT_CHAR, 1'b0, '0},                           // leading dot, then a label
    '{8'h78,    1'b0, '0},
    '{NUL_CHAR, 1'b0, '0},
    '{8'h71,    1'b0, '0},                           // trailing dot
    '{DOT_CHAR, 1'b0, '0},
    '{NUL_CHAR, 1'b1, '{8'h00, 1'b1, 12'd3, 1'b0}},
    '{8'h61,    1'b0, '0},                           // empty label in the middle
    '{DOT_CHAR, 1'b0, '0},
    '{DOT_CHAR, 1'b1, '{8'h00, 1'b0, 12'd3, 1'b0}},
    '{8'h62,    1'b0, '0},
    '{NUL_CHAR, 1'b0, '0}
  };

  logic clk;
  logic rst;

  dnsw_char_if name_ch ();
  dnsw_wire_if wire_ch ();

  dns_name_to_wire_encoder_core u_top (
    .clk     (clk),
    .rst     (rst),
    .name_ch (name_ch),
    .wire_ch (wire_ch)
  );

  // encoder state as the testbench sees it
  logic [CHAR_W-1:0]  lbl_buf [LBL_DEPTH];
  int                 lbl_len;
  bit                 at_start;
  bit                 lead_dot;
  bit                 lbl_cut;
  logic [COUNT_W-1:0] enc_total;

  wire_beat_t wire_bytes_due [$];
  char_row_t  char_rows_sent [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int err_cnt;
  int n_items;
  int n_beats;
  int n_names;
  int n_cut;
  int n_sat;
  int n_sent;

  always #1 clk = ~clk;

  function automatic void clear_name();
    lbl_len   = 0;
    at_start  = 1'b1;
    lead_dot  = 1'b0;
    lbl_cut   = 1'b0;
    enc_total = '0;
  endfunction

  function automatic void push_beat(logic [CHAR_W-1:0] b, bit done, bit ovl);
    wire_beat_t w;
    if (enc_total != COUNT_MAX) enc_total++;
    w.wbyte = b;
    w.done  = done;
    w.cnt   = enc_total;
    w.ovl   = ovl;
    wire_bytes_due.push_back(w);
  endfunction

  function automatic void flush_label(bit done);
    push_beat(CHAR_W'(lbl_len), done && (lbl_len == 0), lbl_cut);
    for (int i = 0; i < lbl_len; i++)
      push_beat(lbl_buf[i], done && (i + 1 == lbl_len), lbl_cut);
    lbl_len = 0;
    lbl_cut = 1'b0;
  endfunction

  function automatic void encode_char(logic [CHAR_W-1:0] c);
    if (at_start) begin
      at_start = 1'b0;
      if (c == DOT_CHAR) begin
        lead_dot = 1'b1;
        return;
      end
    end
    if (lead_dot) begin
      lead_dot = 1'b0;
      if (c == NUL_CHAR) begin
        push_beat(8'h00, 1'b1, 1'b0);
        clear_name();
        return;
      end
      push_beat(8'h00, 1'b0, 1'b0);
    end
    if (c == DOT_CHAR) begin
      flush_label(1'b0);
    end else if (c == NUL_CHAR) begin
      flush_label(1'b1);
      clear_name();
    end else if (lbl_len < LBL_DEPTH) begin
      lbl_buf[lbl_len] = c;
      lbl_len++;
    end else begin
      lbl_cut = 1'b1;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] label_byte();
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom_range(255, 1)); while (b == DOT_CHAR);
    return b;
  endfunction

  // valid stays high from one beat to the next unless a gap is taken
  task automatic put_char(input char_row_t row);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      name_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    char_rows_sent.push_back(row);
    n_sent++;
    name_ch.valid     <= 1'b1;
    name_ch.name_char <= row.ch;
    do @(posedge clk); while (!name_ch.ready);
  endtask

  task automatic send(input logic [CHAR_W-1:0] c);
    char_row_t row;
    row      = '0;
    row.ch   = c;
    put_char(row);
  endtask

  task automatic drain();
    name_ch.valid <= 1'b0;
    @(posedge clk);
    while (wire_bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random_name();
    int  nlab;
    int  len;
    bit  trail;
    if ($urandom_range(9) == 0) begin
      // noise: any byte, dots and NULs included
      repeat ($urandom_range(6, 1)) send(CHAR_W'($urandom_range(255)));
      return;
    end
    trail = ($urandom_range(3) == 0);
    nlab  = $urandom_range(4, 1);
    if ($urandom_range(7) == 0) send(DOT_CHAR);
    for (int l = 0; l < nlab; l++) begin
      len = ($urandom_range(14) == 0) ? $urandom_range(70, 60) : $urandom_range(8, 0);
      repeat (len) send(label_byte());
      if (l + 1 < nlab || trail) send(DOT_CHAR);
    end
    send(NUL_CHAR);
  endtask

  // predict on each accepted character, check each accepted wire beat
  always @(posedge clk) begin : mon
    int         n_before;
    char_row_t  row;
    wire_beat_t got;
    wire_beat_t want;
    if (!rst) begin
      if (name_ch.valid && name_ch.ready) begin
        row      = char_rows_sent.pop_front();
        n_before = wire_bytes_due.size();
        encode_char(name_ch.name_char);
        n_items++;
        if (row.has && (wire_bytes_due.size() == n_before || wire_bytes_due[$] != row.want))
        begin
          $display("%0t directed char %h: expected byte %h done %b count %0d overlong %b",
                   $time, row.ch, row.want.wbyte, row.want.done, row.want.cnt, row.want.ovl);
          err_cnt++;
        end
      end
      if (wire_ch.valid && wire_ch.ready) begin
        got.wbyte = wire_ch.wire_byte;
        got.done  = wire_ch.name_done;
        got.cnt   = wire_ch.wire_count;
        got.ovl   = wire_ch.label_overlong;
        n_beats++;
        if (got.done) n_names++;
        if (got.ovl) n_cut++;
        if (got.cnt == COUNT_MAX) n_sat++;
        if (wire_bytes_due.size() == 0) begin
          $display("%0t unexpected beat: byte %h done %b count %0d overlong %b",
                   $time, got.wbyte, got.done, got.cnt, got.ovl);
          err_cnt++;
        end else begin
          want = wire_bytes_due.pop_front();
          if (got !== want) begin
            $display("%0t mismatch: expected byte %h done %b count %0d overlong %b",
                     $time, want.wbyte, want.done, want.cnt, want.ovl);
            $display("%0t           actual   byte %h done %b count %0d overlong %b",
                     $time, got.wbyte, got.done, got.cnt, got.ovl);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) wire_ch.ready <= 1'b0;
    else     wire_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #2000000;
    $display("tb_dns_name_to_wire_encoder_core: done, errors");
    $finish;
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    name_ch.valid     = 1'b0;
    name_ch.name_char = '0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    err_cnt           = 0;
    n_items           = 0;
    n_beats           = 0;
    n_names           = 0;
    n_cut             = 0;
    n_sat             = 0;
    n_sent            = 0;
    clear_name();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) put_char(DIR_TAB[r]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 76;
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      n_sent = 0;
      while (n_sent < N_RAND / 3) send_random_name();
      drain();
    end

    // leave time for any stray beat to show up
    repeat (80) @(posedge clk);
    if (wire_bytes_due.size() != 0) begin
      $display("%0t %0d expected beats never arrived", $time, wire_bytes_due.size());
      err_cnt++;
    end

    $display("covered %0d characters, %0d wire beats, %0d names ended", n_items, n_beats,
             n_names);
    $display("beats of cut labels %0d, beats at saturated count %0d", n_cut, n_sat);
    if (err_cnt == 0) begin
      $display("tb_dns_name_to_wire_encoder_core: done, clean");
    end else begin
      $display("tb_dns_name_to_wire_encoder_core: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dnsw_pkg.sv
rtl/dnsw_char_if.sv
rtl/dnsw_wire_if.sv
rtl/dns_name_to_wire_encoder_core.sv
rtl/dnsw_checker.sv
tb/tb_dns_name_to_wire_encoder_core.sv
